// File: sv/tcsb_pkg.sv
// Package for the text console scroll buffer: transaction payload types,
// character codes and sequencer states. No dependencies.
`default_nettype none

package tcsb_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_t;

	typedef struct packed {
		logic [6:0] cell_char;
		logic [4:0] line_now;
		logic [6:0] column_now;
		logic       did_scroll;
	} res_t;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_PRINT_LO  = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [6:0] CELL_EMPTY = 7'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_TERM,
		ST_SCROLL
	} state_t;

endpackage

`default_nettype wire

// File: sv/tcsb_chan_if.sv
// Valid/ready channel interface for the text console scroll buffer.
// Payload type is a parameter; used with the tcsb_pkg struct types.
`default_nettype none

interface tcsb_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/tcsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module tcsb_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 2592,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/text_console_scroll_buffer.sv
// Top level of the text console scroll buffer: sequencer around one cell RAM.
// Depends on tcsb_pkg, tcsb_chan_if and tcsb_ram.
//
//   channel  dir  payload        meaning
//   cmd      in   tcsb_pkg::cmd_t put one byte or read one cell
//   res      out  tcsb_pkg::res_t one result per command
//
// A read passes ST_READ; a printable put writes the byte, then a zero in ST_TERM;
// a newline on the last line zeroes the recycled row in ST_SCROLL.
// Rows live in a ring: a scroll moves the top-row pointer and clears one row.
// After reset the RAM is swept once, all ROWS*(COLS+1) cells, with cmd.ready low.
// The result sits in an output register; a new command is taken once it drains.
`default_nettype none

module text_console_scroll_buffer #(
	parameter int ROWS = 32,
	parameter int COLS = 80
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tcsb_chan_if.sink   cmd,
	tcsb_chan_if.source res
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS + 1);
	localparam int DEPTH = ROWS * (COLS + 1);
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
			input logic [RW-1:0] row);
		logic [RW:0] sum;
		sum = {1'b0, base} + {1'b0, row};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
			input logic [CW-1:0] col);
		return AW'(row) * AW'(COLS + 1) + AW'(col);
	endfunction

	tcsb_pkg::state_t state_q, state_d;
	logic [RW-1:0] base_q, base_d;
	logic [RW-1:0] line_q, line_d;
	logic [CW-1:0] col_q, col_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic          rd_ok_q, rd_ok_d;
	logic          res_valid_q;
	tcsb_pkg::res_t res_q, res_d;
	logic          res_load;

	logic          cmd_ready;
	logic          done;
	logic          scrolled;
	logic [6:0]    cell_val;
	logic          rd_ok_now;
	logic [RW-1:0] cur_row;
	logic [RW-1:0] rd_row;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [6:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [6:0]    mem_rdata;

	tcsb_ram #(
		.WIDTH(7),
		.DEPTH(DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign cur_row   = phys_row(base_q, line_q);
	assign rd_row    = phys_row(base_q, RW'(cmd.payload.read_row));
	assign rd_ok_now = ({4'b0, cmd.payload.read_row} < 9'(ROWS))
		&& ({2'b0, cmd.payload.read_col} <= 9'(COLS));
	assign mem_raddr = rd_ok_now ? cell_addr(rd_row, CW'(cmd.payload.read_col)) : '0;

	assign cmd.ready   = cmd_ready;
	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		line_d    = line_q;
		col_d     = col_q;
		sweep_d   = sweep_q;
		rd_ok_d   = rd_ok_q;
		cmd_ready = 1'b0;
		done      = 1'b0;
		scrolled  = 1'b0;
		cell_val  = tcsb_pkg::CELL_EMPTY;
		mem_we    = 1'b0;
		mem_waddr = cell_addr(cur_row, col_q);
		mem_wdata = tcsb_pkg::CELL_EMPTY;
		case (state_q)
			tcsb_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				if (sweep_q == AW'(DEPTH - 1)) begin
					sweep_d = '0;
					state_d = tcsb_pkg::ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			tcsb_pkg::ST_IDLE: begin
				cmd_ready = !res_valid_q || res.ready;
				if (cmd.valid && cmd_ready) begin
					if (cmd.payload.mode == tcsb_pkg::MODE_READ) begin
						rd_ok_d = rd_ok_now;
						state_d = tcsb_pkg::ST_READ;
					end else if (cmd.payload.char_code == tcsb_pkg::CH_NEWLINE
							|| cmd.payload.char_code == tcsb_pkg::CH_RETURN) begin
						col_d = '0;
						if (line_q == RW'(ROWS - 1)) begin
							base_d  = phys_row(base_q, RW'(1));
							sweep_d = '0;
							state_d = tcsb_pkg::ST_SCROLL;
						end else begin
							line_d = line_q + 1'b1;
							done   = 1'b1;
						end
					end else if (cmd.payload.char_code == tcsb_pkg::CH_BACKSPACE) begin
						if (col_q != '0) begin
							col_d     = col_q - 1'b1;
							mem_we    = 1'b1;
							mem_waddr = cell_addr(cur_row, col_q - 1'b1);
						end
						done = 1'b1;
					end else if (cmd.payload.char_code >= tcsb_pkg::CH_PRINT_LO
							&& cmd.payload.char_code <= tcsb_pkg::CH_PRINT_HI) begin
						if (col_q < CW'(COLS)) begin
							mem_we    = 1'b1;
							mem_wdata = cmd.payload.char_code[6:0];
							col_d     = col_q + 1'b1;
							state_d   = tcsb_pkg::ST_TERM;
						end else begin
							done = 1'b1;
						end
					end else begin
						done = 1'b1;
					end
				end
			end
			tcsb_pkg::ST_READ: begin
				cell_val = rd_ok_q ? mem_rdata : tcsb_pkg::CELL_EMPTY;
				done     = 1'b1;
				state_d  = tcsb_pkg::ST_IDLE;
			end
			tcsb_pkg::ST_TERM: begin
				mem_we  = 1'b1;
				done    = 1'b1;
				state_d = tcsb_pkg::ST_IDLE;
			end
			tcsb_pkg::ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(cur_row, sweep_q[CW-1:0]);
				if (sweep_q[CW-1:0] == CW'(COLS)) begin
					sweep_d  = '0;
					done     = 1'b1;
					scrolled = 1'b1;
					state_d  = tcsb_pkg::ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			default: begin
				state_d = tcsb_pkg::ST_IDLE;
			end
		endcase
		res_load         = done;
		res_d.cell_char  = cell_val;
		res_d.line_now   = 5'(line_d);
		res_d.column_now = 7'(col_d);
		res_d.did_scroll = scrolled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcsb_pkg::ST_CLEAR;
			base_q      <= '0;
			line_q      <= '0;
			col_q       <= '0;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			base_q  <= base_d;
			line_q  <= line_d;
			col_q   <= col_d;
			sweep_q <= sweep_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ok_q <= rd_ok_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/tcsb_chk.sv
// Port-level checker for the text console scroll buffer, bound to the top level.
// Depends on tcsb_pkg and text_console_scroll_buffer.
`default_nettype none

module tcsb_chk #(
	parameter int COLS = 80
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_ready,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire tcsb_pkg::res_t res_payload
);

	logic pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			pend_q <= 1'b1;
		end else if (res_valid && res_ready) begin
			pend_q <= 1'b0;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q)
		else $error("result without a pending command");

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> !pend_q || (res_valid && res_ready))
		else $error("command taken while a result is still owed");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 9'(res_payload.column_now) <= 9'(COLS))
		else $error("column beyond row width");

	a_scroll_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.did_scroll |->
			res_payload.column_now == '0 && res_payload.cell_char == '0)
		else $error("scroll result with nonzero column or cell");

endmodule

bind text_console_scroll_buffer tcsb_chk #(.COLS(COLS)) u_tcsb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_payload(res.payload)
);

`default_nettype wire
